/* src/nsv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsv_pkg
// Shared types, constants and the hex_value helper function for the NMEA
// sentence validator.
// ----------------------------------------------------------------------------
package nsv_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;

   localparam logic [3:0] PREFIX_LEN = 4'd6;
   localparam logic [3:0] XOR_START  = 4'd4;
   localparam logic [3:0] MIN_LEN    = 4'd11;
   localparam logic [3:0] CHAR_SAT   = 4'd11;
   localparam logic [4:0] COMMA_SAT  = 5'd31;

   localparam logic [4:0] COMMAS_GGA = 5'd14;
   localparam logic [4:0] COMMAS_RMC = 5'd12;
   localparam logic [4:0] COMMAS_GSA = 5'd17;

   // $GPGGA, $GPRMC, $GPGSA, $GPGSV
   localparam logic [7:0] PREFIX_TAB [4][6] = '{
      '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41},
      '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43},
      '{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h41},
      '{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h56}
   };

   typedef enum logic [2:0] {
      KIND_NONE = 3'd0,
      KIND_GGA  = 3'd1,
      KIND_RMC  = 3'd2,
      KIND_GSA  = 3'd3,
      KIND_GSV  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SHORT    = 3'd1,
      ST_PREFIX   = 3'd2,
      ST_COMMAS   = 3'd3,
      ST_CHECKSUM = 3'd4
   } status_type;

   // sentence state captured at line feed
   typedef struct packed {
      logic [3:0] char_count;
      logic [4:0] comma_count;
      logic [3:0] prefix_match;
      logic [7:0] running_xor;
      logic [7:0] digit_hi;
      logic [7:0] digit_lo;
   } sent_rec_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_value(input logic [7:0] c);
      hex_type r;
      r.valid = 1'b1;
      r.value = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r.value = 4'(c - 8'h30);
      end else if (c inside {[8'h61:8'h66]}) begin
         r.value = 4'(c - 8'h57);
      end else if (c inside {[8'h41:8'h46]}) begin
         r.value = 4'(c - 8'h37);
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

endpackage

/* src/nsv_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsv_front
// Byte intake: tracks prefix match, commas, length and the running XOR, and
// hands a sentence record to the verdict queue on each line feed.
// ----------------------------------------------------------------------------
module nsv_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [7:0]            req_line_byte,
   input  logic                  q_full,
   output logic                  q_push,
   output nsv_pkg::sent_rec_type q_data
);
   import nsv_pkg::*;

   logic [7:0] running_xor_ff, running_xor_in;
   logic [7:0] recent_ff [3];
   logic [7:0] recent_in [3];
   logic [3:0] char_count_ff, char_count_in;
   logic [4:0] comma_count_ff, comma_count_in;
   logic [3:0] prefix_match_ff, prefix_match_in;
   logic       accept;

   assign req_full = q_full;
   assign accept   = req_push & ~q_full;

   always_comb begin
      running_xor_in  = running_xor_ff;
      recent_in       = recent_ff;
      char_count_in   = char_count_ff;
      comma_count_in  = comma_count_ff;
      prefix_match_in = prefix_match_ff;
      q_push          = 1'b0;

      q_data.char_count   = char_count_ff;
      q_data.comma_count  = comma_count_ff;
      q_data.prefix_match = prefix_match_ff;
      q_data.running_xor  = running_xor_ff;
      q_data.digit_hi     = recent_ff[1];
      q_data.digit_lo     = recent_ff[2];

      if (accept) begin
         if (req_line_byte == CHAR_LF) begin
            q_push          = 1'b1;
            running_xor_in  = 8'h00;
            recent_in       = '{8'h00, 8'h00, 8'h00};
            char_count_in   = 4'd0;
            comma_count_in  = 5'd0;
            prefix_match_in = 4'hF;
         end else if (req_line_byte != CHAR_CR) begin
            if (char_count_ff < PREFIX_LEN) begin
               for (int k = 0; k < 4; k++) begin
                  if (PREFIX_TAB[k][char_count_ff[2:0]] != req_line_byte) begin
                     prefix_match_in[k] = 1'b0;
                  end
               end
            end
            if (char_count_ff >= XOR_START) begin
               running_xor_in = running_xor_ff ^ recent_ff[0];
            end
            recent_in[0] = recent_ff[1];
            recent_in[1] = recent_ff[2];
            recent_in[2] = req_line_byte;
            if (req_line_byte == CHAR_COMMA && comma_count_ff < COMMA_SAT) begin
               comma_count_in = comma_count_ff + 5'd1;
            end
            if (char_count_ff < CHAR_SAT) begin
               char_count_in = char_count_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_xor_ff  <= 8'h00;
         recent_ff       <= '{8'h00, 8'h00, 8'h00};
         char_count_ff   <= 4'd0;
         comma_count_ff  <= 5'd0;
         prefix_match_ff <= 4'hF;
      end else begin
         running_xor_ff  <= running_xor_in;
         recent_ff       <= recent_in;
         char_count_ff   <= char_count_in;
         comma_count_ff  <= comma_count_in;
         prefix_match_ff <= prefix_match_in;
      end
   end

endmodule

/* src/nsv_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsv_queue
// Small register queue of sentence records between intake and verdict.
// ----------------------------------------------------------------------------
module nsv_queue #(
   parameter int DEPTH = nsv_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  nsv_pkg::sent_rec_type wr_data,
   output logic                  full,
   input  logic                  rd_en,
   output nsv_pkg::sent_rec_type rd_data,
   output logic                  empty
);
   import nsv_pkg::*;

   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   sent_rec_type     slot_ff [DEPTH];
   logic [IdxW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CntW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_ff + IdxW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_ff + IdxW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CntW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(DEPTH))
      else $error("queue count beyond depth");

   a_write_lands: assert property (@(posedge clock) disable iff (reset)
      (do_wr && !do_rd) |=> !empty)
      else $error("write left queue empty");

   a_read_drains: assert property (@(posedge clock) disable iff (reset)
      (do_rd && !do_wr) |=> !full)
      else $error("read left queue full");

endmodule

/* src/nsv_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsv_back
// Verdict stage: decodes kind, parses the hex checksum, ranks the status and
// holds the result for the consumer.
// ----------------------------------------------------------------------------
module nsv_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  nsv_pkg::sent_rec_type q_data,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [2:0]            rsp_sentence_kind,
   output logic [2:0]            rsp_status,
   output logic [7:0]            rsp_computed_sum,
   output logic [7:0]            rsp_received_sum
);
   import nsv_pkg::*;

   logic       valid_ff;
   kind_type   kind_ff, kind_in;
   status_type status_ff, status_in;
   logic [7:0] csum_ff, csum_in;
   logic [7:0] rsum_ff, rsum_in;
   hex_type    hi, lo;
   logic       comma_check;
   logic [4:0] comma_need;

   assign q_pop     = ~q_empty & (~valid_ff | rsp_pop);
   assign rsp_empty = ~valid_ff;

   assign rsp_sentence_kind = kind_ff;
   assign rsp_status        = status_ff;
   assign rsp_computed_sum  = csum_ff;
   assign rsp_received_sum  = rsum_ff;

   assign hi = hex_value(q_data.digit_hi);
   assign lo = hex_value(q_data.digit_lo);

   always_comb begin
      kind_in = KIND_NONE;
      if (q_data.char_count >= PREFIX_LEN) begin
         if (q_data.prefix_match[0]) begin
            kind_in = KIND_GGA;
         end else if (q_data.prefix_match[1]) begin
            kind_in = KIND_RMC;
         end else if (q_data.prefix_match[2]) begin
            kind_in = KIND_GSA;
         end else if (q_data.prefix_match[3]) begin
            kind_in = KIND_GSV;
         end
      end

      case (kind_in)
         KIND_GGA: begin
            comma_check = 1'b1;
            comma_need  = COMMAS_GGA;
         end
         KIND_RMC: begin
            comma_check = 1'b1;
            comma_need  = COMMAS_RMC;
         end
         KIND_GSA: begin
            comma_check = 1'b1;
            comma_need  = COMMAS_GSA;
         end
         default: begin
            comma_check = 1'b0;
            comma_need  = 5'd0;
         end
      endcase

      csum_in   = 8'h00;
      rsum_in   = 8'h00;
      status_in = ST_OK;
      if (q_data.char_count < MIN_LEN) begin
         status_in = ST_SHORT;
      end else begin
         csum_in = q_data.running_xor;
         if (hi.valid) begin
            rsum_in = lo.valid ? {hi.value, lo.value} : {4'h0, hi.value};
         end
         if (kind_in == KIND_NONE) begin
            status_in = ST_PREFIX;
         end else if (comma_check && q_data.comma_count != comma_need) begin
            status_in = ST_COMMAS;
         end else if (csum_in != rsum_in) begin
            status_in = ST_CHECKSUM;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         kind_ff   <= kind_in;
         status_ff <= status_in;
         csum_ff   <= csum_in;
         rsum_ff   <= rsum_in;
      end
   end

   a_ok_sums_agree: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && status_ff == ST_OK) |-> (csum_ff == rsum_ff))
      else $error("accepted verdict with differing sums");

   a_short_zero_sums: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && status_ff == ST_SHORT) |-> (csum_ff == 8'h00 && rsum_ff == 8'h00))
      else $error("short sentence with non-zero sums");

   a_no_kind_status: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == KIND_NONE) |-> (status_ff == ST_SHORT || status_ff == ST_PREFIX))
      else $error("unknown kind with later-stage status");

endmodule

/* src/nmea_sentence_validator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_validator
// NMEA 0183 sentence checker: one verdict per line feed.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while req_full is low, with no gaps needed. Carriage
// returns are dropped, a line feed closes the sentence and yields one verdict
// (kind, status, computed and received checksum). With the result side
// draining, a verdict reaches the rsp_ ports by way of the verdict queue and
// then the checksum parse and status ranking into the output register.
// req_full rises only when the verdict queue (QUEUE_DEPTH transactions) and
// the output register are both occupied.
module nmea_sentence_validator #(
   parameter int QUEUE_DEPTH = nsv_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_line_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [2:0] rsp_sentence_kind,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_computed_sum,
   output logic [7:0] rsp_received_sum
);
   import nsv_pkg::*;

   sent_rec_type wr_rec, rd_rec;
   logic         q_push, q_full, q_pop, q_empty;

   nsv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_line_byte (req_line_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (wr_rec)
   );

   nsv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (wr_rec),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (rd_rec),
      .empty   (q_empty)
   );

   nsv_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_data            (rd_rec),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_sentence_kind (rsp_sentence_kind),
      .rsp_status        (rsp_status),
      .rsp_computed_sum  (rsp_computed_sum),
      .rsp_received_sum  (rsp_received_sum)
   );

endmodule
